// ===== hdl/hcys_pkg.sv =====
// Package for the homography centroid yaw servo: widths, register codes,
// reset values and the structs passed between the pipeline modules.
// Used by every other file of the block.
package hcys_pkg;

   // Field widths of the channels and registers.
   localparam int ID_W       = 17;
   localparam int TID_W      = 16;
   localparam int DIM_W      = 12;
   localparam int HOM_W      = 48;
   localparam int CX_W       = 12;
   localparam int GAIN_W     = 20;
   localparam int LIM_W      = 12;
   localparam int SRCH_W     = 13;
   localparam int OUT_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   // Projection arithmetic widths.
   localparam int PROD_W  = HOM_W + DIM_W + 1;
   localparam int SUM_W   = PROD_W + 1;
   localparam int MAG_W   = SUM_W - 1;
   localparam int FRAC_W  = 8;
   localparam int QB      = 32;
   localparam int R_W     = MAG_W + FRAC_W;
   localparam int CMP_W   = MAG_W + QB;
   localparam int SAT_SH  = QB - FRAC_W;
   localparam int SATC_W  = MAG_W + SAT_SH;
   localparam int CQ_W    = QB + 2;
   localparam int CSUM_W  = CQ_W + 2;
   localparam int CENT_SH = 10;
   localparam int CQV_W   = CSUM_W - CENT_SH;
   localparam int ERR_W   = 18;
   localparam int P_W     = GAIN_W + 1 + ERR_W;
   localparam int RATE_SH = 12;
   localparam int RT_W    = P_W - RATE_SH;

   localparam int CORNERS   = 4;
   localparam int LANES     = 2 * CORNERS;
   localparam int NEAR_ZERO = 512;

   // Register reset values.
   localparam logic [TID_W-1:0]         TARGET_ID_RST = TID_W'(5);
   localparam logic [CX_W-1:0]          CENTER_X_RST  = CX_W'(320);
   localparam logic [GAIN_W-1:0]        GAIN_RST      = GAIN_W'(33554);
   localparam logic [LIM_W-1:0]         MIN_RATE_RST  = LIM_W'(410);
   localparam logic [LIM_W-1:0]         MAX_RATE_RST  = LIM_W'(1024);
   localparam logic signed [SRCH_W-1:0] SEARCH_RST    = SRCH_W'(1024);

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CFG_TARGET_ID   = 3'd0,
      CFG_CENTER_X    = 3'd1,
      CFG_RATE_GAIN   = 3'd2,
      CFG_MIN_RATE    = 3'd3,
      CFG_MAX_RATE    = 3'd4,
      CFG_SEARCH_RATE = 3'd5
   } cfg_idx_type;

   typedef struct packed {
      logic [TID_W-1:0]         target_id;
      logic [CX_W-1:0]          image_center_x;
      logic [GAIN_W-1:0]        rate_gain;
      logic [LIM_W-1:0]         min_rate;
      logic [LIM_W-1:0]         max_rate;
      logic signed [SRCH_W-1:0] search_rate;
   } cfg_type;

   typedef struct packed {
      logic signed [ID_W-1:0]  object_id;
      logic [DIM_W-1:0]        object_width;
      logic [DIM_W-1:0]        object_height;
      logic signed [HOM_W-1:0] hom_r0c0;
      logic signed [HOM_W-1:0] hom_r1c0;
      logic signed [HOM_W-1:0] hom_r2c0;
      logic signed [HOM_W-1:0] hom_r0c1;
      logic signed [HOM_W-1:0] hom_r1c1;
      logic signed [HOM_W-1:0] hom_r2c1;
      logic signed [HOM_W-1:0] hom_r0c2;
      logic signed [HOM_W-1:0] hom_r1c2;
      logic signed [HOM_W-1:0] hom_r2c2;
   } req_type;

   // One division lane: magnitudes, result sign and special-case flags.
   typedef struct packed {
      logic             neg;
      logic             zero;
      logic             sat;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] b;
   } div_lane_type;

   typedef struct packed {
      logic                          trk;
      div_lane_type [LANES-1:0]      lane;
   } div_in_type;

   // Running state of one lane inside the divider.
   typedef struct packed {
      logic             neg;
      logic             zero;
      logic             sat;
      logic [MAG_W-1:0] b;
      logic [R_W-1:0]   r;
      logic [QB-1:0]    q;
   } div_state_type;

   typedef struct packed {
      logic                        trk;
      logic [LANES-1:0][CQ_W-1:0]  coord;
   } div_out_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] turn_rate;
      logic                    tracking;
      logic signed [OUT_W-1:0] centroid_x;
      logic signed [OUT_W-1:0] centroid_y;
   } rsp_type;

endpackage

// ===== hdl/hcys_req_if.sv =====
// Detection input channel: valid/ready handshake and the detection payload.
// Depends on hcys_pkg for field widths.
interface hcys_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [hcys_pkg::ID_W-1:0]  object_id;
   logic [hcys_pkg::DIM_W-1:0]        object_width;
   logic [hcys_pkg::DIM_W-1:0]        object_height;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r0c0;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r1c0;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r2c0;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r0c1;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r1c1;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r2c1;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r0c2;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r1c2;
   logic signed [hcys_pkg::HOM_W-1:0] hom_r2c2;

   modport source (
      output valid, object_id, object_width, object_height,
      output hom_r0c0, hom_r1c0, hom_r2c0, hom_r0c1, hom_r1c1, hom_r2c1,
      output hom_r0c2, hom_r1c2, hom_r2c2,
      input  ready
   );
   modport sink (
      input  valid, object_id, object_width, object_height,
      input  hom_r0c0, hom_r1c0, hom_r2c0, hom_r0c1, hom_r1c1, hom_r2c1,
      input  hom_r0c2, hom_r1c2, hom_r2c2,
      output ready
   );
endinterface

// ===== hdl/hcys_rsp_if.sv =====
// Result channel: valid/ready handshake and the turn command payload.
// Depends on hcys_pkg for field widths.
interface hcys_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [hcys_pkg::OUT_W-1:0] turn_rate;
   logic                             tracking;
   logic signed [hcys_pkg::OUT_W-1:0] centroid_x;
   logic signed [hcys_pkg::OUT_W-1:0] centroid_y;

   modport source (
      output valid, turn_rate, tracking, centroid_x, centroid_y,
      input  ready
   );
   modport sink (
      input  valid, turn_rate, tracking, centroid_x, centroid_y,
      output ready
   );
endinterface

// ===== hdl/hcys_csr_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on hcys_pkg for field widths.
interface hcys_csr_if;
   logic                              valid;
   logic                              ready;
   logic [hcys_pkg::CSR_ADDR_W-1:0]   index;
   logic [hcys_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/hcys_regs.sv =====
// Configuration register file of the yaw servo.
// Depends on hcys_pkg for register codes, widths and reset values.
module hcys_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hcys_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [hcys_pkg::CSR_DATA_W-1:0] csr_data,
   output hcys_pkg::cfg_type               cfg
);
   import hcys_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode a write transaction into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (cfg_idx_type'(csr_index))
            CFG_TARGET_ID:   cfg_in.target_id      = csr_data[TID_W-1:0];
            CFG_CENTER_X:    cfg_in.image_center_x = csr_data[CX_W-1:0];
            CFG_RATE_GAIN:   cfg_in.rate_gain      = csr_data[GAIN_W-1:0];
            CFG_MIN_RATE:    cfg_in.min_rate       = csr_data[LIM_W-1:0];
            CFG_MAX_RATE:    cfg_in.max_rate       = csr_data[LIM_W-1:0];
            CFG_SEARCH_RATE: cfg_in.search_rate    = $signed(csr_data[SRCH_W-1:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_id      <= TARGET_ID_RST;
         cfg_ff.image_center_x <= CENTER_X_RST;
         cfg_ff.rate_gain      <= GAIN_RST;
         cfg_ff.min_rate       <= MIN_RATE_RST;
         cfg_ff.max_rate       <= MAX_RATE_RST;
         cfg_ff.search_rate    <= SEARCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/hcys_proj.sv =====
// Front of the pipeline: id match, homography products, corner sums and
// the operand preparation for the projective divide (four stages).
// Depends on hcys_pkg.
module hcys_proj (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   output logic                 in_rdy,
   input  hcys_pkg::req_type    in_data,
   input  hcys_pkg::cfg_type    cfg,
   output logic                 out_vld,
   input  logic                 out_rdy,
   output hcys_pkg::div_in_type out_data
);
   import hcys_pkg::*;

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic en1, en2, en3, en4;

   logic                     trk1_ff, trk2_ff, trk3_ff;
   logic signed [PROD_W-1:0] prod1_ff [6];
   logic signed [PROD_W-1:0] prod_in  [6];
   logic signed [HOM_W-1:0]  off1_ff  [3];
   logic signed [SUM_W-1:0]  sum2_ff  [3][CORNERS];
   logic signed [SUM_W-1:0]  sum_in   [3][CORNERS];
   div_lane_type [LANES-1:0] lane3_ff, lane3_in;
   div_in_type               out4_ff, out4_in;
   logic                     trk_in;
   logic signed [DIM_W:0]    wd, ht;

   // A stage loads when it is empty or its successor moves.
   assign en4    = !vld4_ff || out_rdy;
   assign en3    = !vld3_ff || en4;
   assign en2    = !vld2_ff || en3;
   assign en1    = !vld1_ff || en2;
   assign in_rdy = en1;

   assign out_vld  = vld4_ff;
   assign out_data = out4_ff;

   // Stage 1: id match and the six coordinate-dependent products.
   always_comb begin
      wd        = $signed({1'b0, in_data.object_width});
      ht        = $signed({1'b0, in_data.object_height});
      trk_in    = !in_data.object_id[ID_W-1] &&
                  (in_data.object_id[TID_W-1:0] == cfg.target_id);
      prod_in[0] = $signed(in_data.hom_r0c0) * wd;
      prod_in[1] = $signed(in_data.hom_r0c1) * ht;
      prod_in[2] = $signed(in_data.hom_r1c0) * wd;
      prod_in[3] = $signed(in_data.hom_r1c1) * ht;
      prod_in[4] = $signed(in_data.hom_r2c0) * wd;
      prod_in[5] = $signed(in_data.hom_r2c1) * ht;
   end

   // Stage 2: numerators and divisor for each corner.
   always_comb begin
      logic signed [SUM_W-1:0] tx, ty;
      for (int row = 0; row < 3; row++) begin
         for (int c = 0; c < CORNERS; c++) begin
            tx = ((c & 1) != 0) ? SUM_W'(prod1_ff[2*row])   : '0;
            ty = ((c & 2) != 0) ? SUM_W'(prod1_ff[2*row+1]) : '0;
            sum_in[row][c] = SUM_W'(off1_ff[row]) + tx + ty;
         end
      end
   end

   // Stage 3: magnitudes, quotient sign and the near-zero divisor test.
   always_comb begin
      logic signed [SUM_W-1:0] wv, nv;
      logic [MAG_W-1:0]        wm;
      logic                    wz;
      lane3_in = '0;
      for (int c = 0; c < CORNERS; c++) begin
         wv = sum2_ff[2][c];
         wm = MAG_W'(wv[SUM_W-1] ? -wv : wv);
         wz = (wm <= MAG_W'(NEAR_ZERO));
         for (int row = 0; row < 2; row++) begin
            nv = sum2_ff[row][c];
            lane3_in[row*CORNERS+c].a    = MAG_W'(nv[SUM_W-1] ? -nv : nv);
            lane3_in[row*CORNERS+c].b    = wm;
            lane3_in[row*CORNERS+c].neg  = nv[SUM_W-1] ^ wv[SUM_W-1];
            lane3_in[row*CORNERS+c].zero = wz;
            lane3_in[row*CORNERS+c].sat  = 1'b0;
         end
      end
   end

   // Stage 4: integer part at or above 2^24 saturates the corner.
   always_comb begin
      out4_in.trk  = trk3_ff;
      out4_in.lane = lane3_ff;
      for (int l = 0; l < LANES; l++) begin
         out4_in.lane[l].sat = (SATC_W'(lane3_ff[l].a) >=
                                (SATC_W'(lane3_ff[l].b) << SAT_SH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (en1) vld1_ff <= in_vld;
         if (en2) vld2_ff <= vld1_ff;
         if (en3) vld3_ff <= vld2_ff;
         if (en4) vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         trk1_ff    <= trk_in;
         prod1_ff   <= prod_in;
         off1_ff[0] <= in_data.hom_r0c2;
         off1_ff[1] <= in_data.hom_r1c2;
         off1_ff[2] <= in_data.hom_r2c2;
      end
      if (en2) begin
         trk2_ff <= trk1_ff;
         sum2_ff <= sum_in;
      end
      if (en3) begin
         trk3_ff  <= trk2_ff;
         lane3_ff <= lane3_in;
      end
      if (en4) begin
         out4_ff <= out4_in;
      end
   end

endmodule

// ===== hdl/hcys_div.sv =====
// Pipelined restoring divider: eight lanes, one quotient bit per stage,
// giving |num|/|w| in Q.8 with the corner special cases applied at the end.
// Depends on hcys_pkg.
module hcys_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   output logic                  in_rdy,
   input  hcys_pkg::div_in_type  in_data,
   output logic                  out_vld,
   input  logic                  out_rdy,
   output hcys_pkg::div_out_type out_data
);
   import hcys_pkg::*;

   div_state_type [LANES-1:0] st_ff  [QB];
   div_state_type [LANES-1:0] src    [QB];
   logic [QB-1:0]             vld_ff, trk_ff, src_vld, src_trk;
   logic [QB:0]               en;

   assign en[QB]  = out_rdy;
   assign in_rdy  = en[0];
   assign out_vld = vld_ff[QB-1];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int SH = QB - 1 - s;
      div_state_type [LANES-1:0] st_in;

      assign en[s] = !vld_ff[s] || en[s+1];

      // Source of this stage: the incoming operands or the stage before.
      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src[0][l].neg  = in_data.lane[l].neg;
               src[0][l].zero = in_data.lane[l].zero;
               src[0][l].sat  = in_data.lane[l].sat;
               src[0][l].b    = in_data.lane[l].b;
               src[0][l].r    = R_W'(in_data.lane[l].a) << FRAC_W;
               src[0][l].q    = '0;
            end
         end
         assign src_vld[0] = in_vld;
         assign src_trk[0] = in_data.trk;
      end else begin : g_next
         assign src[s]     = st_ff[s-1];
         assign src_vld[s] = vld_ff[s-1];
         assign src_trk[s] = trk_ff[s-1];
      end

      // Subtract the shifted divisor where it fits and set this quotient bit.
      always_comb begin
         logic [CMP_W-1:0] d;
         st_in = src[s];
         for (int l = 0; l < LANES; l++) begin
            d = CMP_W'(src[s][l].b) << SH;
            if (CMP_W'(src[s][l].r) >= d) begin
               st_in[l].r     = src[s][l].r - d[R_W-1:0];
               st_in[l].q[SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en[s]) begin
            vld_ff[s] <= src_vld[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            st_ff[s]  <= st_in;
            trk_ff[s] <= src_trk[s];
         end
      end
   end

   // Apply sign, saturation and the near-zero divisor case.
   always_comb begin
      logic [QB-1:0] mag;
      out_data.trk = trk_ff[QB-1];
      for (int l = 0; l < LANES; l++) begin
         if (st_ff[QB-1][l].zero) begin
            mag = '0;
         end else if (st_ff[QB-1][l].sat) begin
            mag = '1;
         end else begin
            mag = st_ff[QB-1][l].q;
         end
         out_data.coord[l] = st_ff[QB-1][l].neg ? -CQ_W'(mag) : CQ_W'(mag);
      end
   end

   // A held result at the end of the divider stays valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QB-1] && !out_rdy |=> vld_ff[QB-1])
      else $error("divider output dropped while stalled");

   // The first stage never takes a transaction while it is full and blocked.
   a_block: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !en[1] |-> !in_rdy)
      else $error("divider accepted into a blocked stage");

   // Corner 0 gives the same near-zero divisor flag on its x and y lanes.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QB-1] |-> st_ff[QB-1][0].zero == st_ff[QB-1][CORNERS].zero)
      else $error("corner lanes disagree on near-zero divisor");

endmodule

// ===== hdl/hcys_rate.sv =====
// Back of the pipeline: corner sum, centroid, proportional rate, deadband
// and clamp, with the search-rate choice in the output register.
// Depends on hcys_pkg.
module hcys_rate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   output logic                  in_rdy,
   input  hcys_pkg::div_out_type in_data,
   input  hcys_pkg::cfg_type     cfg,
   output logic                  out_vld,
   input  logic                  out_rdy,
   output hcys_pkg::rsp_type     out_data
);
   import hcys_pkg::*;

   localparam logic signed [CSUM_W-1:0] CENT_RND = CSUM_W'((1 << CENT_SH) - 1);
   localparam logic signed [P_W-1:0]    RATE_RND = P_W'((1 << RATE_SH) - 1);
   localparam logic signed [CQV_W-1:0]  C_MAX    = CQV_W'(32767);
   localparam logic signed [CQV_W-1:0]  C_MIN    = -CQV_W'(32768);

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic en1, en2, en3, en4;

   logic                     trk1_ff, trk2_ff, trk3_ff;
   logic signed [CSUM_W-1:0] sx1_ff, sy1_ff, sx_in, sy_in;
   logic signed [OUT_W-1:0]  cx2_ff, cy2_ff, cx_in, cy_in;
   logic signed [OUT_W-1:0]  cx3_ff, cy3_ff;
   logic signed [P_W-1:0]    p3_ff, p_in;
   logic signed [ERR_W-1:0]  err;
   rsp_type                  out4_ff, out4_in;

   assign en4    = !vld4_ff || out_rdy;
   assign en3    = !vld3_ff || en4;
   assign en2    = !vld2_ff || en3;
   assign en1    = !vld1_ff || en2;
   assign in_rdy = en1;

   assign out_vld  = vld4_ff;
   assign out_data = out4_ff;

   // Stage 1: sum the four corners in Q.8.
   always_comb begin
      sx_in = '0;
      sy_in = '0;
      for (int c = 0; c < CORNERS; c++) begin
         sx_in = sx_in + CSUM_W'($signed(in_data.coord[c]));
         sy_in = sy_in + CSUM_W'($signed(in_data.coord[CORNERS+c]));
      end
   end

   // Stage 2: divide by four corners and 256, toward zero, then saturate.
   always_comb begin
      logic signed [CSUM_W-1:0] ax, ay;
      logic signed [CQV_W-1:0]  qx, qy;
      ax = sx1_ff + (sx1_ff[CSUM_W-1] ? CENT_RND : '0);
      ay = sy1_ff + (sy1_ff[CSUM_W-1] ? CENT_RND : '0);
      qx = ax[CSUM_W-1:CENT_SH];
      qy = ay[CSUM_W-1:CENT_SH];
      if (qx > C_MAX)      cx_in = C_MAX[OUT_W-1:0];
      else if (qx < C_MIN) cx_in = C_MIN[OUT_W-1:0];
      else                 cx_in = qx[OUT_W-1:0];
      if (qy > C_MAX)      cy_in = C_MAX[OUT_W-1:0];
      else if (qy < C_MIN) cy_in = C_MIN[OUT_W-1:0];
      else                 cy_in = qy[OUT_W-1:0];
   end

   // Stage 3: gain times horizontal error, Q.24.
   always_comb begin
      err  = $signed(ERR_W'(cfg.image_center_x)) - ERR_W'(cx2_ff);
      p_in = $signed({1'b0, cfg.rate_gain}) * err;
   end

   // Stage 4: scale to Q3.12, deadband, clamp, or the search rate.
   always_comb begin
      logic signed [P_W-1:0]  pa;
      logic signed [RT_W-1:0] r, mx;
      logic [RT_W-1:0]        mag;
      pa  = p3_ff + (p3_ff[P_W-1] ? RATE_RND : '0);
      r   = pa[P_W-1:RATE_SH];
      mag = r[RT_W-1] ? RT_W'(-r) : RT_W'(r);
      mx  = $signed(RT_W'(cfg.max_rate));
      if (mag < RT_W'(cfg.min_rate)) begin
         r = '0;
      end else if (r > mx) begin
         r = mx;
      end else if (r < -mx) begin
         r = -mx;
      end
      if (trk3_ff) begin
         out4_in.turn_rate  = r[OUT_W-1:0];
         out4_in.tracking   = 1'b1;
         out4_in.centroid_x = cx3_ff;
         out4_in.centroid_y = cy3_ff;
      end else begin
         out4_in.turn_rate  = OUT_W'(cfg.search_rate);
         out4_in.tracking   = 1'b0;
         out4_in.centroid_x = '0;
         out4_in.centroid_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (en1) vld1_ff <= in_vld;
         if (en2) vld2_ff <= vld1_ff;
         if (en3) vld3_ff <= vld2_ff;
         if (en4) vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         trk1_ff <= in_data.trk;
         sx1_ff  <= sx_in;
         sy1_ff  <= sy_in;
      end
      if (en2) begin
         trk2_ff <= trk1_ff;
         cx2_ff  <= cx_in;
         cy2_ff  <= cy_in;
      end
      if (en3) begin
         trk3_ff <= trk2_ff;
         cx3_ff  <= cx2_ff;
         cy3_ff  <= cy2_ff;
         p3_ff   <= p_in;
      end
      if (en4) begin
         out4_ff <= out4_in;
      end
   end

   // An untracked result carries no centroid.
   a_no_cent: assert property (@(posedge clock) disable iff (reset)
      vld4_ff && !out4_ff.tracking |->
         out4_ff.centroid_x == '0 && out4_ff.centroid_y == '0)
      else $error("centroid set on a search result");

   // A tracked rate never exceeds the clamp limit.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      vld4_ff && out4_ff.tracking |->
         $signed(out4_ff.turn_rate) <= $signed({4'b0, cfg.max_rate}) &&
         $signed(out4_ff.turn_rate) >= -$signed({4'b0, cfg.max_rate}))
      else $error("turn rate beyond clamp limit");

   // A nonzero tracked rate passed the deadband or sits on the clamp.
   a_dead: assert property (@(posedge clock) disable iff (reset)
      vld4_ff && out4_ff.tracking && out4_ff.turn_rate != '0 |->
         ($signed(out4_ff.turn_rate) >= $signed({4'b0, cfg.min_rate})) ||
         (-$signed(out4_ff.turn_rate) >= $signed({4'b0, cfg.min_rate})) ||
         ($signed(out4_ff.turn_rate) == $signed({4'b0, cfg.max_rate})) ||
         (-$signed(out4_ff.turn_rate) == $signed({4'b0, cfg.max_rate})))
      else $error("nonzero rate inside the deadband");

endmodule

// ===== hdl/homography_centroid_yaw_servo.sv =====
// Channel   | Direction | Handshake    | Payload
// req_if    | in        | valid/ready  | object id, size, 3x3 homography Q15.32
// rsp_if    | out       | valid/ready  | turn_rate, tracking, centroid_x/y
// csr_if    | in        | valid/ready  | register index, write data
//
// One detection is accepted per clock while the result channel does not
// stall; each passes through 4 projection stages, 32 divider stages and 4
// rate stages. Most of that depth lies in the restoring divider, which resolves
// one quotient bit per stage for all eight corner coordinates at once.
// Reset clears every valid bit and loads the register defaults.
// Each stage holds while its successor is full and stalled; bubbles fill.
// Top level of the yaw servo; depends on hcys_pkg, the channel interfaces,
// hcys_regs, hcys_proj, hcys_div and hcys_rate.
module homography_centroid_yaw_servo (
   input  logic       clock,
   input  logic       reset,
   hcys_req_if.sink   req_if,
   hcys_rsp_if.source rsp_if,
   hcys_csr_if.sink   csr_if
);
   import hcys_pkg::*;

   cfg_type     cfg;
   req_type     req_data;
   div_in_type  proj_data;
   div_out_type div_data;
   rsp_type     rsp_data;
   logic        proj_vld, proj_rdy, div_vld, div_rdy;

   // Gather the request fields into one payload.
   always_comb begin
      req_data.object_id     = req_if.object_id;
      req_data.object_width  = req_if.object_width;
      req_data.object_height = req_if.object_height;
      req_data.hom_r0c0      = req_if.hom_r0c0;
      req_data.hom_r1c0      = req_if.hom_r1c0;
      req_data.hom_r2c0      = req_if.hom_r2c0;
      req_data.hom_r0c1      = req_if.hom_r0c1;
      req_data.hom_r1c1      = req_if.hom_r1c1;
      req_data.hom_r2c1      = req_if.hom_r2c1;
      req_data.hom_r0c2      = req_if.hom_r0c2;
      req_data.hom_r1c2      = req_if.hom_r1c2;
      req_data.hom_r2c2      = req_if.hom_r2c2;
   end

   hcys_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_if.valid),
      .csr_ready (csr_if.ready),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .cfg       (cfg)
   );

   hcys_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (req_if.valid),
      .in_rdy   (req_if.ready),
      .in_data  (req_data),
      .cfg      (cfg),
      .out_vld  (proj_vld),
      .out_rdy  (proj_rdy),
      .out_data (proj_data)
   );

   hcys_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (proj_vld),
      .in_rdy   (proj_rdy),
      .in_data  (proj_data),
      .out_vld  (div_vld),
      .out_rdy  (div_rdy),
      .out_data (div_data)
   );

   hcys_rate u_rate (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (div_vld),
      .in_rdy   (div_rdy),
      .in_data  (div_data),
      .cfg      (cfg),
      .out_vld  (rsp_if.valid),
      .out_rdy  (rsp_if.ready),
      .out_data (rsp_data)
   );

   assign rsp_if.turn_rate  = rsp_data.turn_rate;
   assign rsp_if.tracking   = rsp_data.tracking;
   assign rsp_if.centroid_x = rsp_data.centroid_x;
   assign rsp_if.centroid_y = rsp_data.centroid_y;

endmodule

// ===== bench/hcys_tb_if.sv =====
`timescale 1ns / 100ps
// Bench-side notes for the servo channels: the channel interfaces come from the RTL.
// This file holds the helper package of expected-result types; depends on hcys_pkg.
package hcys_tb_pkg;
   import hcys_pkg::*;

   // One expected turn command, as the servo should deliver it.
   typedef struct packed {
      logic signed [OUT_W-1:0] turn_rate;
      logic                    tracking;
      logic signed [OUT_W-1:0] centroid_x;
      logic signed [OUT_W-1:0] centroid_y;
   } turn_cmd_type;
endpackage

// ===== bench/homography_centroid_yaw_servo_tb.sv =====
`timescale 1ns / 100ps
// Testbench for homography_centroid_yaw_servo: random and directed detections,
// a built-in servo predictor, and a checking monitor. Depends on hcys_pkg,
// the RTL channel interfaces and hcys_tb_pkg.
module homography_centroid_yaw_servo_tb;
   import hcys_pkg::*;
   import hcys_tb_pkg::*;

   localparam int IDLE_PCT    = 18;
   localparam int WATCHDOG    = 20000;
   localparam int DRAIN_WAIT  = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcys_req_if req_if ();
   hcys_rsp_if rsp_if ();
   hcys_csr_if csr_if ();

   homography_centroid_yaw_servo u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Shadow copy of the servo registers.
   cfg_type servo_cfg;

   req_type      pending_dets[$];
   turn_cmd_type expected_cmds[$];
   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   bit  no_idle        = 1'b0;
   bit  timed_out      = 1'b0;

   // Test clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Corner coordinate num/den truncated toward zero in Q.8, saturated.
   function automatic longint corner_q8(longint num, longint den);
      logic [63:0] a, b, q, r, mag;
      bit neg;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q = a / b;
      r = a % b;
      if (q >= 64'd16777216) begin
         mag = 64'd4294967295;
      end else begin
         mag = q;
         for (int i = 0; i < 8; i++) begin
            r = r << 1;
            mag = mag << 1;
            if (r >= b) begin
               r = r - b;
               mag[0] = 1'b1;
            end
         end
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Predicts the turn command for one detection under the current registers.
   function automatic turn_cmd_type predict_turn(req_type d);
      turn_cmd_type c;
      longint h[3][3];
      longint sx, sy, xx, yy, nx, ny, w, cx, cy, rate, mag;
      sx = 0;
      sy = 0;
      c = '0;
      h[0][0] = longint'(d.hom_r0c0);
      h[1][0] = longint'(d.hom_r1c0);
      h[2][0] = longint'(d.hom_r2c0);
      h[0][1] = longint'(d.hom_r0c1);
      h[1][1] = longint'(d.hom_r1c1);
      h[2][1] = longint'(d.hom_r2c1);
      h[0][2] = longint'(d.hom_r0c2);
      h[1][2] = longint'(d.hom_r1c2);
      h[2][2] = longint'(d.hom_r2c2);
      if (d.object_id >= 0 && longint'(d.object_id) == longint'(servo_cfg.target_id)) begin
         for (int i = 0; i < CORNERS; i++) begin
            xx = i[0] ? longint'(d.object_width) : 0;
            yy = i[1] ? longint'(d.object_height) : 0;
            nx = h[0][0] * xx + h[0][1] * yy + h[0][2];
            ny = h[1][0] * xx + h[1][1] * yy + h[1][2];
            w  = h[2][0] * xx + h[2][1] * yy + h[2][2];
            if (w > NEAR_ZERO || w < -NEAR_ZERO) begin
               sx += corner_q8(nx, w);
               sy += corner_q8(ny, w);
            end
         end
         cx = clamp16(sx / 1024);
         cy = clamp16(sy / 1024);
         rate = longint'(servo_cfg.rate_gain) * (longint'(servo_cfg.image_center_x) - cx);
         rate = rate / 4096;
         mag = (rate < 0) ? -rate : rate;
         if (mag < longint'(servo_cfg.min_rate)) begin
            rate = 0;
         end else begin
            if (rate > longint'(servo_cfg.max_rate)) rate = longint'(servo_cfg.max_rate);
            if (rate < -longint'(servo_cfg.max_rate)) rate = -longint'(servo_cfg.max_rate);
         end
         c.turn_rate  = rate[15:0];
         c.tracking   = 1'b1;
         c.centroid_x = cx[15:0];
         c.centroid_y = cy[15:0];
      end else begin
         c.turn_rate = OUT_W'(servo_cfg.search_rate);
      end
      return c;
   endfunction

   function automatic logic signed [HOM_W-1:0] rand_hom();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[HOM_W-1:0];
   endfunction

   // Mild perspective homography around an identity-like map.
   function automatic req_type sane_det(logic signed [ID_W-1:0] id, int dim_max);
      req_type d;
      longint one;
      one = 64'sd1 << 32;
      d.object_id     = id;
      d.object_width  = DIM_W'($urandom_range(dim_max, 0));
      d.object_height = DIM_W'($urandom_range(dim_max, 0));
      d.hom_r0c0 = HOM_W'(one + $signed($urandom_range(65535, 0)) * 32768 - one / 2);
      d.hom_r1c0 = HOM_W'($signed($urandom_range(65535, 0) - 32768) * 8192);
      d.hom_r2c0 = HOM_W'($signed($urandom_range(4095, 0) - 2048) * 64);
      d.hom_r0c1 = HOM_W'($signed($urandom_range(65535, 0) - 32768) * 8192);
      d.hom_r1c1 = HOM_W'(one + $signed($urandom_range(65535, 0)) * 32768 - one / 2);
      d.hom_r2c1 = HOM_W'($signed($urandom_range(4095, 0) - 2048) * 64);
      d.hom_r0c2 = HOM_W'($signed($urandom_range(1000, 0)) * one - 200 * one);
      d.hom_r1c2 = HOM_W'($signed($urandom_range(1000, 0)) * one - 200 * one);
      d.hom_r2c2 = HOM_W'(one + $signed($urandom_range(65535, 0)) * 16384 - one / 4);
      return d;
   endfunction

   function automatic req_type noise_det(logic signed [ID_W-1:0] id);
      req_type d;
      d.object_id     = id;
      d.object_width  = DIM_W'($urandom);
      d.object_height = DIM_W'($urandom);
      d.hom_r0c0 = rand_hom(); d.hom_r1c0 = rand_hom(); d.hom_r2c0 = rand_hom();
      d.hom_r0c1 = rand_hom(); d.hom_r1c1 = rand_hom(); d.hom_r2c1 = rand_hom();
      d.hom_r0c2 = rand_hom(); d.hom_r1c2 = rand_hom(); d.hom_r2c2 = rand_hom();
      return d;
   endfunction

   // Appends one detection to the tail of the pending queue.
   task automatic queue_det(req_type d);
      pending_dets.insert(pending_dets.size(), d);
   endtask

   // Writes one register through the configuration channel.
   task automatic write_reg(cfg_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CFG_TARGET_ID:   servo_cfg.target_id      = value[TID_W-1:0];
         CFG_CENTER_X:    servo_cfg.image_center_x = value[CX_W-1:0];
         CFG_RATE_GAIN:   servo_cfg.rate_gain      = value[GAIN_W-1:0];
         CFG_MIN_RATE:    servo_cfg.min_rate       = value[LIM_W-1:0];
         CFG_MAX_RATE:    servo_cfg.max_rate       = value[LIM_W-1:0];
         CFG_SEARCH_RATE: servo_cfg.search_rate    = value[SRCH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [15:0] tid, logic [11:0] ctr, logic [19:0] gain,
                            logic [11:0] lo, logic [11:0] hi, logic [12:0] srch);
      write_reg(CFG_TARGET_ID, CSR_DATA_W'(tid));
      write_reg(CFG_CENTER_X, CSR_DATA_W'(ctr));
      write_reg(CFG_RATE_GAIN, gain);
      write_reg(CFG_MIN_RATE, CSR_DATA_W'(lo));
      write_reg(CFG_MAX_RATE, CSR_DATA_W'(hi));
      write_reg(CFG_SEARCH_RATE, CSR_DATA_W'(srch));
   endtask

   // Waits until the pipeline has delivered every expected transaction.
   task automatic drain();
      while (pending_dets.size() != 0 || expected_cmds.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      logic signed [ID_W-1:0] id;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9, 0))
            0: id = ID_W'(-1);
            1: id = ID_W'($urandom);
            default: id = ID_W'(servo_cfg.target_id);
         endcase
         if ($urandom_range(9, 0) < 2) queue_det(noise_det(id));
         else if ($urandom_range(9, 0) == 0) queue_det(sane_det(id, 4095));
         else queue_det(sane_det(id, 640));
      end
   endtask

   // Stimulus and register phases.
   initial begin
      req_type d;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data  = '0;
      servo_cfg = '{TARGET_ID_RST, CENTER_X_RST, GAIN_RST, MIN_RATE_RST,
                    MAX_RATE_RST, SEARCH_RST};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed detections at reset settings.
      queue_det(sane_det(ID_W'(5), 640));
      d = sane_det(ID_W'(5), 640);
      d.object_width = 12'hFFF;
      d.object_height = 12'hFFF;
      queue_det(d);
      d = sane_det(ID_W'(5), 0);
      queue_det(d);
      queue_det(sane_det(ID_W'(-1), 640));
      queue_det(sane_det(17'sh10000, 640));
      queue_det(sane_det(-17'sd5, 640));
      // Near-zero divisor: w zero, w just at the limit and w just beyond it.
      d = sane_det(ID_W'(5), 640);
      d.hom_r2c0 = '0; d.hom_r2c1 = '0; d.hom_r2c2 = '0;
      queue_det(d);
      d.hom_r2c2 = HOM_W'(NEAR_ZERO);
      queue_det(d);
      d.hom_r2c2 = HOM_W'(-NEAR_ZERO - 1);
      queue_det(d);
      // Huge quotients saturate the corners and the centroid.
      d = sane_det(ID_W'(5), 640);
      d.hom_r0c2 = 48'sh7FFF_FFFF_FFFF;
      d.hom_r1c2 = 48'sh8000_0000_0000;
      d.hom_r2c0 = '0; d.hom_r2c1 = '0; d.hom_r2c2 = 48'sd1024;
      queue_det(d);
      d.hom_r0c2 = 48'sh8000_0000_0000;
      d.hom_r1c2 = 48'sh7FFF_FFFF_FFFF;
      queue_det(d);
      for (int i = 0; i < 4; i++) queue_det(noise_det(ID_W'(5)));
      drain();

      // Extreme register settings, inverted limits included.
      write_all(16'hFFFF, 12'hFFF, 20'hFFFFF, 12'd0, 12'hFFF, 13'h1000);
      queue_det(sane_det(17'sh0FFFF, 640));
      queue_det(sane_det(ID_W'(-1), 640));
      random_phase(150);
      drain();
      write_all(16'd0, 12'd0, 20'd0, 12'hFFF, 12'd0, 13'h0FFF);
      write_reg(cfg_idx_type'(3'd7), 20'hABCDE);
      write_reg(cfg_idx_type'(3'd6), 20'h12345);
      random_phase(100);
      drain();
      write_all(16'd42, 12'd320, 20'd200000, 12'd2000, 12'd100, 13'h1F00);
      random_phase(150);
      drain();
      write_all(16'd7, 12'd640, 20'd33554, 12'd410, 12'd1024, 13'd1024);
      no_idle = 1'b1;
      random_phase(200);
      drain();
      no_idle = 1'b0;
      for (int k = 0; k < 4; k++) begin
         write_all(TID_W'($urandom), CX_W'($urandom), GAIN_W'($urandom),
                   LIM_W'($urandom_range(600, 0)), LIM_W'($urandom_range(4095, 300)),
                   SRCH_W'($urandom));
         random_phase(140);
         drain();
      end

      if (mismatch_count == 0 && !timed_out) begin
         $display("homography_centroid_yaw_servo test passed");
      end else begin
         $display("homography_centroid_yaw_servo test failed");
      end
      $finish;
   end

   // Detection driver; the predictor runs on each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.object_id     <= '0;
         req_if.object_width  <= '0;
         req_if.object_height <= '0;
         req_if.hom_r0c0 <= '0; req_if.hom_r1c0 <= '0; req_if.hom_r2c0 <= '0;
         req_if.hom_r0c1 <= '0; req_if.hom_r1c1 <= '0; req_if.hom_r2c1 <= '0;
         req_if.hom_r0c2 <= '0; req_if.hom_r1c2 <= '0; req_if.hom_r2c2 <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_cmds.insert(expected_cmds.size(),
                                 predict_turn(pending_dets.pop_front()));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_dets.size() != 0 &&
                (no_idle || $urandom_range(99, 0) >= IDLE_PCT)) begin
               req_if.valid         <= 1'b1;
               req_if.object_id     <= pending_dets[0].object_id;
               req_if.object_width  <= pending_dets[0].object_width;
               req_if.object_height <= pending_dets[0].object_height;
               req_if.hom_r0c0 <= pending_dets[0].hom_r0c0;
               req_if.hom_r1c0 <= pending_dets[0].hom_r1c0;
               req_if.hom_r2c0 <= pending_dets[0].hom_r2c0;
               req_if.hom_r0c1 <= pending_dets[0].hom_r0c1;
               req_if.hom_r1c1 <= pending_dets[0].hom_r1c1;
               req_if.hom_r2c1 <= pending_dets[0].hom_r2c1;
               req_if.hom_r0c2 <= pending_dets[0].hom_r0c2;
               req_if.hom_r1c2 <= pending_dets[0].hom_r1c2;
               req_if.hom_r2c2 <= pending_dets[0].hom_r2c2;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      turn_cmd_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_idle || $urandom_range(99, 0) >= IDLE_PCT;
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.turn_rate, rsp_if.tracking, rsp_if.centroid_x,
                    rsp_if.centroid_y};
            if (expected_cmds.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected turn command %p", got);
            end else begin
               want = expected_cmds.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("turn command mismatch: expected %p, got %p", want, got);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles > WATCHDOG) begin
            timed_out = 1'b1;
            $display("homography_centroid_yaw_servo test failed");
            $finish;
         end
      end
   end
endmodule

// ===== filelist.f =====
hdl/hcys_pkg.sv
hdl/hcys_req_if.sv
hdl/hcys_rsp_if.sv
hdl/hcys_csr_if.sv
hdl/hcys_regs.sv
hdl/hcys_proj.sv
hdl/hcys_div.sv
hdl/hcys_rate.sv
hdl/homography_centroid_yaw_servo.sv
bench/hcys_tb_if.sv
bench/homography_centroid_yaw_servo_tb.sv
